// ===== rtl/core/isa_pkg.sv =====
// package for the indexed shift array core
// holds field widths, operation and status codes, fsm states and cell commands
// no dependencies
package isa_pkg;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_DELETE = 3'd3,
      OP_REMOVE = 3'd4,
      OP_READ   = 3'd5,
      OP_WRITE  = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_FULL    = 3'd3,
      ST_MISSING = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_FIND = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LOAD  = 2'd1,
      CELL_UP    = 2'd2,
      CELL_DOWN  = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type     mode;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== rtl/core/isa_cell.sv =====
// one storage cell of the indexed shift array
// holds one entry, takes from its neighbors on shifts, flags a value match
// depends on isa_pkg
module isa_cell #(
   parameter int IW    = 6,
   parameter int CW    = 7,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  isa_pkg::cell_cmd_type      cmd,
   input  logic [IW-1:0]              idx,
   input  logic [CW-1:0]              count,
   input  logic [isa_pkg::DATA_W-1:0] left_data,
   input  logic [isa_pkg::DATA_W-1:0] right_data,
   output logic [isa_pkg::DATA_W-1:0] data,
   output logic [isa_pkg::DATA_W-1:0] rd_part,
   output logic                       hit
);
   import isa_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.mode)
         CELL_LOAD: begin
            if (MY_IDX == idx) data_in = cmd.value;
         end
         CELL_UP: begin
            if (MY_IDX > idx) data_in = left_data;
            else if (MY_IDX == idx) data_in = cmd.value;
         end
         CELL_DOWN: begin
            if (MY_IDX >= idx) data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_part = (MY_IDX == idx) ? data_ff : '0;
   assign hit     = (data_ff == cmd.value) && (MY_CNT < count);

endmodule

// ===== rtl/core/isa_row.sv =====
// row of storage cells chained neighbor to neighbor
// gathers the per-cell match flags and the selected read entry
// depends on isa_pkg and isa_cell
module isa_row #(
   parameter int DEPTH = 64,
   parameter int IW    = 6,
   parameter int CW    = 7
) (
   input  logic                       clock,
   input  isa_pkg::cell_cmd_type      cmd,
   input  logic [IW-1:0]              idx,
   input  logic [CW-1:0]              count,
   output logic [DEPTH-1:0]           hit,
   output logic [isa_pkg::DATA_W-1:0] rd_data
);
   import isa_pkg::*;

   logic [DATA_W-1:0] data    [DEPTH];
   logic [DATA_W-1:0] rd_part [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = data[i];
      end else begin : g_mid_l
         assign left_d = data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_d = data[i];
      end else begin : g_mid_r
         assign right_d = data[i+1];
      end

      isa_cell #(
         .IW    (IW),
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (idx),
         .count      (count),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (data[i]),
         .rd_part    (rd_part[i]),
         .hit        (hit[i])
      );
   end

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_data = rd_data | rd_part[i];
      end
   end

endmodule

// ===== rtl/core/indexed_shift_array_core.sv =====
// top level of the indexed shift array core
// request decode, sequencing, element count and result register
// depends on isa_pkg and isa_row
//
// usage:
//   req channel carries one operation per transfer (operation, position,
//   operand_value); rsp channel returns one result per request (read_data,
//   status, element_count) in request order.
//   req_ready is high while the sequencer is idle. the result of a request
//   is loaded into the rsp register in the execute state after its transfer,
//   the cycle in which the cell row shifts, loads or is read; the sequencer
//   is idle again after it, so a new request is taken only after the last
//   result is loaded. a remove on a non-empty array adds the find state: the
//   match flags of all cells are registered in execute, then the first hit
//   is selected, the row shifts down from it and the result is loaded.
//   a new request is taken while a finished result waits in the rsp
//   register; if the receiver stalls, the next result waits in the
//   sequencer until the rsp register is free.
//   reset clears the element count, the sequencer and rsp_valid; entry
//   contents are left as they are and are only read after being written.
module indexed_shift_array_core #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [isa_pkg::OP_W-1:0]     req_operation,
   input  logic [isa_pkg::POS_W-1:0]    req_position,
   input  logic [isa_pkg::DATA_W-1:0]   req_operand_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [isa_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [isa_pkg::STATUS_W-1:0] rsp_status,
   output logic [isa_pkg::COUNT_W-1:0]  rsp_element_count
);
   import isa_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [DEPTH-1:0]  hit_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   status_type        rsp_status_ff;
   logic [CW-1:0]     rsp_count_ff;

   logic [DEPTH-1:0]  row_hit;
   logic [DATA_W-1:0] row_rd;
   cell_cmd_type      cmd;
   cell_mode_type     mode;
   logic [IW-1:0]     idx;
   logic              done;
   logic              fire;
   status_type        status;
   logic [DATA_W-1:0] rd;
   logic [CW-1:0]     count_op;

   logic [XW-1:0]     pos_x;
   logic [XW-1:0]     cnt_x;
   logic              in_range;
   logic              full;
   logic              empty;
   logic [DEPTH-1:0]  first_hit;
   logic [IW-1:0]     hit_idx;
   logic              found;
   logic              accept;

   assign pos_x    = XW'(pos_ff);
   assign cnt_x    = XW'(count_ff);
   assign in_range = pos_x < cnt_x;
   assign full     = count_ff == FULL_CNT;
   assign empty    = count_ff == '0;
   assign found    = |hit_ff;
   assign first_hit = hit_ff & (~hit_ff + DEPTH'(1));

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hit[i]) hit_idx = hit_idx | IW'(i);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = done && (!rsp_valid_ff || rsp_ready);

   // outputs of the sequencer
   always_comb begin
      done     = 1'b0;
      status   = ST_OK;
      rd       = '0;
      mode     = CELL_HOLD;
      idx      = IW'(pos_ff);
      count_op = count_ff;
      case (state_ff)
         S_EXEC: begin
            done = 1'b1;
            case (op_ff)
               OP_PUSH: begin
                  if (full) begin
                     status = ST_FULL;
                  end else begin
                     mode     = CELL_LOAD;
                     idx      = IW'(count_ff);
                     count_op = count_ff + CW'(1);
                  end
               end
               OP_POP: begin
                  if (empty) status = ST_EMPTY;
                  else count_op = count_ff - CW'(1);
               end
               OP_INSERT: begin
                  if (!in_range) begin
                     status = ST_RANGE;
                  end else if (full) begin
                     status = ST_FULL;
                  end else begin
                     mode     = CELL_UP;
                     count_op = count_ff + CW'(1);
                  end
               end
               OP_DELETE: begin
                  if (!in_range) begin
                     status = ST_RANGE;
                  end else begin
                     mode     = CELL_DOWN;
                     count_op = count_ff - CW'(1);
                  end
               end
               OP_REMOVE: begin
                  if (empty) status = ST_EMPTY;
                  else done = 1'b0;
               end
               OP_READ: begin
                  if (!in_range) status = ST_RANGE;
                  else rd = row_rd;
               end
               OP_WRITE: begin
                  if (!in_range) status = ST_RANGE;
                  else mode = CELL_LOAD;
               end
               default: begin
                  status = ST_OK;
               end
            endcase
         end
         S_FIND: begin
            done = 1'b1;
            if (found) begin
               mode     = CELL_DOWN;
               idx      = hit_idx;
               count_op = count_ff - CW'(1);
            end else begin
               status = ST_MISSING;
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   assign cmd.mode  = fire ? mode : CELL_HOLD;
   assign cmd.value = val_ff;
   assign count_in  = fire ? count_op : count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == OP_REMOVE && !empty) state_in = S_FIND;
            else if (fire) state_in = S_IDLE;
         end
         S_FIND: begin
            if (fire) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_operation);
         pos_ff <= req_position;
         val_ff <= req_operand_value;
      end
      if (state_ff == S_EXEC) hit_ff <= row_hit;
      if (fire) begin
         rsp_data_ff   <= rd;
         rsp_status_ff <= status;
         rsp_count_ff  <= count_op;
      end
   end

   isa_row #(
      .DEPTH (DEPTH),
      .IW    (IW),
      .CW    (CW)
   ) u_row (
      .clock   (clock),
      .cmd     (cmd),
      .idx     (idx),
      .count   (count_ff),
      .hit     (row_hit),
      .rd_data (row_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = COUNT_W'(rsp_count_ff);

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("element count above depth");

   a_find_from_remove: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> (op_ff == OP_REMOVE) &&
         ($past(state_ff) == S_EXEC || $past(state_ff) == S_FIND))
      else $error("match select entered outside remove");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff == S_EXEC && op_ff == OP_PUSH && status == ST_OK)
         |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the count");
`endif

endmodule
